@@ design/mlxd_pkg.sv @@
package mlxd_pkg;

  localparam int unsigned PhaseW = 2;
  localparam logic [PhaseW-1:0] PHASE_HUNT    = 2'd0;
  localparam logic [PhaseW-1:0] PHASE_LENGTH  = 2'd1;
  localparam logic [PhaseW-1:0] PHASE_PAYLOAD = 2'd2;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_MARKER      = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_VALUE_WRITE = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DESCRIPTION = 2'd2;

  localparam logic [7:0] MARKER_RESET      = 8'd170;
  localparam logic [7:0] VALUE_WRITE_RESET = 8'd1;
  localparam logic [7:0] DESCRIPTION_RESET = 8'd2;

  localparam logic KIND_PAYLOAD   = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  localparam logic TYPE_VALUE_WRITE = 1'b0;
  localparam logic TYPE_DESCRIPTION = 1'b1;

  typedef struct packed {
    logic [7:0] marker_value;
    logic [7:0] value_write_type;
    logic [7:0] description_type;
  } cfg_regs_t;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] data_byte;
    logic [7:0] byte_offset;
    logic       frame_type;
    logic       check_ok;
  } result_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              marker_seen;
    logic [7:0]        bytes_taken;
    logic [7:0]        payload_length;
  } parse_status_t;

endpackage

@@ design/marker_length_xor_deframer_core.sv @@
// A result passes through the input register and then the result register before it is on the
// output ports. Throughput: one byte per cycle while the result register takes results. The whole
// per-byte parse step is one combinational pass between the two registers. A stalled result
// register also holds back bytes that give no result.
// Reset: synchronous; clears the parser to hunting, empties both registers and
// loads the marker and type code registers with their default values.
module marker_length_xor_deframer_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          item_kind,
  output logic [7:0]                    data_byte,
  output logic [7:0]                    byte_offset,
  output logic                          frame_type,
  output logic                          check_ok,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mlxd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [7:0]                    cfg_data
);
  import mlxd_pkg::*;

  cfg_regs_t     regs;
  result_t       res;
  result_t       out_res;
  parse_status_t status;
  logic          res_valid;
  logic          res_ready;

  mlxd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  mlxd_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .regs      (regs),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res),
    .status    (status)
  );

  mlxd_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign item_kind   = out_res.item_kind;
  assign data_byte   = out_res.data_byte;
  assign byte_offset = out_res.byte_offset;
  assign frame_type  = out_res.frame_type;
  assign check_ok    = out_res.check_ok;

`ifndef NO_ASSERTIONS
  // A payload byte never carries a pass flag.
  a_payload_no_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && item_kind == KIND_PAYLOAD) |-> !check_ok)
    else $error("payload result with check_ok set");

  // The payload count never runs past the declared length.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (status.phase == PHASE_PAYLOAD) |-> (status.bytes_taken <= status.payload_length))
    else $error("payload count exceeds length");

  // A length byte is only expected after a marker was seen.
  a_length_after_marker: assert property (@(posedge clk) disable iff (rst)
    (status.phase == PHASE_LENGTH) |-> status.marker_seen)
    else $error("length phase without marker");

  // With the result register empty, the input side must accept.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");
`endif

endmodule

@@ design/mlxd_cfg.sv @@
module mlxd_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mlxd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [7:0]                    cfg_data,
  output mlxd_pkg::cfg_regs_t           regs
);
  import mlxd_pkg::*;

  assign cfg_ready = 1'b1;

  // A transfer to an index past the register list is taken and dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.marker_value     <= MARKER_RESET;
      regs.value_write_type <= VALUE_WRITE_RESET;
      regs.description_type <= DESCRIPTION_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MARKER:      regs.marker_value     <= cfg_data;
        REG_VALUE_WRITE: regs.value_write_type <= cfg_data;
        REG_DESCRIPTION: regs.description_type <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ design/mlxd_parse.sv @@
module mlxd_parse (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              rx_byte,
  input  mlxd_pkg::cfg_regs_t     regs,
  input  logic                    res_ready,
  output logic                    res_valid,
  output mlxd_pkg::result_t       res,
  output mlxd_pkg::parse_status_t status
);
  import mlxd_pkg::*;

  logic             held_valid;
  logic [7:0]       held_byte;
  logic             take;

  logic [PhaseW-1:0] phase, phase_next;
  logic              marker_seen, marker_seen_next;
  logic              current_type, current_type_next;
  logic [7:0]        payload_length, payload_length_next;
  logic [7:0]        bytes_taken, bytes_taken_next;
  logic [7:0]        running_xor, running_xor_next;

  // The held byte is consumed whenever the result register can take what it yields.
  assign take     = held_valid && res_ready;
  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= rx_byte;
    end
  end

  always_comb begin
    phase_next          = phase;
    marker_seen_next    = marker_seen;
    current_type_next   = current_type;
    payload_length_next = payload_length;
    bytes_taken_next    = bytes_taken;
    running_xor_next    = running_xor;
    res_valid           = 1'b0;
    res.item_kind       = KIND_PAYLOAD;
    res.data_byte       = held_byte;
    res.byte_offset     = bytes_taken;
    res.frame_type      = current_type;
    res.check_ok        = 1'b0;

    unique case (phase)
      PHASE_LENGTH: begin
        payload_length_next = held_byte;
        bytes_taken_next    = 8'd0;
        running_xor_next    = 8'd0;
        phase_next          = PHASE_PAYLOAD;
      end
      PHASE_PAYLOAD: begin
        res_valid = held_valid;
        if (bytes_taken < payload_length) begin
          running_xor_next = running_xor ^ held_byte;
          bytes_taken_next = bytes_taken + 8'd1;
        end else begin
          res.item_kind    = KIND_FRAME_END;
          res.byte_offset  = payload_length;
          res.check_ok     = (running_xor == held_byte);
          phase_next       = PHASE_HUNT;
          marker_seen_next = 1'b0;
        end
      end
      default: begin
        // Hunting; the unused phase code lands here as well.
        phase_next = PHASE_HUNT;
        if (held_byte == regs.marker_value) begin
          marker_seen_next = 1'b1;
        end else if (marker_seen) begin
          if (held_byte == regs.value_write_type) begin
            current_type_next = TYPE_VALUE_WRITE;
            phase_next        = PHASE_LENGTH;
          end else if (held_byte == regs.description_type) begin
            current_type_next = TYPE_DESCRIPTION;
            phase_next        = PHASE_LENGTH;
          end else begin
            marker_seen_next = 1'b0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PHASE_HUNT;
      marker_seen    <= 1'b0;
      current_type   <= 1'b0;
      payload_length <= 8'd0;
      bytes_taken    <= 8'd0;
      running_xor    <= 8'd0;
    end else if (take) begin
      phase          <= phase_next;
      marker_seen    <= marker_seen_next;
      current_type   <= current_type_next;
      payload_length <= payload_length_next;
      bytes_taken    <= bytes_taken_next;
      running_xor    <= running_xor_next;
    end
  end

  assign status.phase          = phase;
  assign status.marker_seen    = marker_seen;
  assign status.bytes_taken    = bytes_taken;
  assign status.payload_length = payload_length;

endmodule

@@ design/mlxd_out.sv @@
module mlxd_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  output logic              res_ready,
  input  mlxd_pkg::result_t res,
  output logic              out_valid,
  input  logic              out_ready,
  output mlxd_pkg::result_t out_res
);
  import mlxd_pkg::*;

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

endmodule
